[sv/leg_torque_constraint_rows_core_defines.svh]
// Assertion macros for the leg torque constraint rows block.
// Used by the port checker; no other dependencies.
`ifndef LEG_TORQUE_CONSTRAINT_ROWS_CORE_DEFINES_SVH
`define LEG_TORQUE_CONSTRAINT_ROWS_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LTCR_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ltcr check failed");

// next-cycle implication, disabled during reset
`define LTCR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ltcr check failed");

`endif

[sv/ltcr_pkg.sv]
// Shared types, constants and helper functions of the leg torque constraint rows block.
// No dependencies.
`default_nettype none

package ltcr_pkg;

    localparam int unsigned ADDR_W = 4;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_LIMIT_HIP   = 2'd0;
    localparam t_reg_idx REG_LIMIT_UPPER = 2'd1;
    localparam t_reg_idx REG_LIMIT_LOWER = 2'd2;

    localparam logic [30:0] RESET_LIMIT_HIP   = 31'd41984983;
    localparam logic [30:0] RESET_LIMIT_UPPER = 31'd109660078;
    localparam logic [30:0] RESET_LIMIT_LOWER = 31'd86968893;

    localparam logic signed [47:0] INV_TWO_PI_Q32 = 48'sd683565276;
    localparam logic [30:0]        HALF_PI_Q30    = 31'd1686629713;
    localparam logic [30:0]        ONE_Q30        = 31'h4000_0000;
    localparam logic signed [18:0] OFFSET_Q17     = 19'sd23593;
    localparam logic signed [40:0] GRAV_K1        = 41'sd6471802;
    localparam logic signed [40:0] GRAV_K2        = 41'sd1189669;
    localparam logic signed [40:0] GRAV_K3        = 41'sd558798;

    localparam logic [2:0] SLOT_SIN_HIP   = 3'd0;
    localparam logic [2:0] SLOT_COS_HIP   = 3'd1;
    localparam logic [2:0] SLOT_SIN_UPPER = 3'd2;
    localparam logic [2:0] SLOT_COS_UPPER = 3'd3;
    localparam logic [2:0] SLOT_SIN_SUM   = 3'd4;
    localparam logic [2:0] SLOT_COS_SUM   = 3'd5;
    localparam logic [2:0] SLOT_LAST      = SLOT_COS_SUM;
    localparam logic [2:0] ROW_LAST       = 3'd5;
    localparam logic [2:0] ROW_NEG_FIRST  = 3'd3;

    localparam int unsigned TAYLOR_STEPS = 5;

    // floor(v/d) == (v*m) >> (32+l) for all 32-bit v, m = floor(2^(32+l)/d)+1
    localparam logic [63:0] TAYLOR_M0 = (64'd1 << 39) / 64'd110 + 64'd1;
    localparam logic [63:0] TAYLOR_M1 = (64'd1 << 39) / 64'd72 + 64'd1;
    localparam logic [63:0] TAYLOR_M2 = (64'd1 << 38) / 64'd42 + 64'd1;
    localparam logic [63:0] TAYLOR_M3 = (64'd1 << 37) / 64'd20 + 64'd1;
    localparam logic [63:0] TAYLOR_M4 = (64'd1 << 35) / 64'd6 + 64'd1;

    typedef enum logic [1:0] {
        COL_HIP,
        COL_UPPER,
        COL_LOWER
    } t_col;

    typedef struct packed {
        logic [2:0]         leg_index;
        logic signed [15:0] angle_hip;
        logic signed [15:0] angle_upper;
        logic signed [15:0] angle_lower;
        logic               final_leg;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         leg_number;
        logic [2:0]         row_in_leg;
        logic signed [31:0] coef_first;
        logic signed [31:0] coef_second;
        logic signed [31:0] coef_third;
        logic signed [31:0] row_bound;
        logic               last_row;
        logic               last_of_set;
    } t_out_item;

    typedef struct packed {
        logic [2:0] leg;
        logic       final_leg;
        logic [2:0] slot;
    } t_tag;

    typedef struct packed {
        logic               valid;
        t_tag               tag;
        logic signed [16:0] angle;
        logic               is_cos;
    } t_sin_req;

    typedef struct packed {
        logic        valid;
        t_tag        tag;
        logic        neg;
        logic [30:0] x;
        logic [31:0] x2;
        logic [30:0] t;
    } t_sin_data;

    typedef struct packed {
        logic               valid;
        t_tag               tag;
        logic signed [17:0] value;
    } t_sin_res;

    typedef struct packed {
        logic [2:0]         leg;
        logic               final_leg;
        logic signed [17:0] s1;
        logic signed [17:0] c1;
        logic signed [17:0] s2;
        logic signed [17:0] c2;
        logic signed [17:0] s23;
        logic signed [17:0] c23;
    } t_trig;

    typedef struct packed {
        logic [30:0] hip;
        logic [30:0] upper;
        logic [30:0] lower;
    } t_limits;

    function automatic logic [32:0] taylor_magic(input logic [2:0] step);
        logic [32:0] m;
        case (step)
            3'd0:    m = TAYLOR_M0[32:0];
            3'd1:    m = TAYLOR_M1[32:0];
            3'd2:    m = TAYLOR_M2[32:0];
            3'd3:    m = TAYLOR_M3[32:0];
            default: m = TAYLOR_M4[32:0];
        endcase
        return m;
    endfunction

    function automatic logic [5:0] taylor_shift(input logic [2:0] step);
        logic [5:0] s;
        case (step)
            3'd0:    s = 6'd39;
            3'd1:    s = 6'd39;
            3'd2:    s = 6'd38;
            3'd3:    s = 6'd37;
            default: s = 6'd35;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

[sv/ltcr_taylor_cell.sv]
// One Horner step of the sine series: t = 1 - x2*t/d, two register stages.
// Depends on ltcr_pkg.
`default_nettype none

module ltcr_taylor_cell (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_en,
    input  wire  [2:0]            i_step,
    input  ltcr_pkg::t_sin_data   i_d,
    output ltcr_pkg::t_sin_data   o_d
);
    import ltcr_pkg::*;

    logic [62:0] w_prod;
    logic [64:0] w_mq;
    logic [64:0] w_q;
    logic [31:0] n_v;
    logic [31:0] r_v;
    t_sin_data   r_mid;
    t_sin_data   n_out;
    t_sin_data   r_out;

    assign w_prod = 63'(i_d.x2) * 63'(i_d.t);
    assign n_v    = w_prod[61:30];

    assign w_mq = 65'(r_v) * 65'(taylor_magic(i_step));
    assign w_q  = w_mq >> taylor_shift(i_step);

    always_comb begin
        n_out   = r_mid;
        n_out.t = 31'(32'(ONE_Q30) - w_q[31:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid.valid <= 1'b0;
            r_out.valid <= 1'b0;
        end else if (i_en) begin
            r_mid <= i_d;
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v <= n_v;
        end
    end

    assign o_d = r_out;

endmodule

`default_nettype wire

[sv/ltcr_sine_pipe.sv]
// Sine pipeline: phase, quadrant fold, scaling, chain of Taylor cells, rounding.
// Depends on ltcr_pkg and ltcr_taylor_cell.
`default_nettype none

module ltcr_sine_pipe (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  ltcr_pkg::t_sin_req   i_req,
    output ltcr_pkg::t_sin_res   o_res
);
    import ltcr_pkg::*;

    typedef struct packed {
        logic        valid;
        t_tag        tag;
        logic [31:0] phase;
    } t_phase;

    logic signed [47:0] w_pm;
    logic signed [47:0] w_pr;
    t_phase             n_ph;
    t_phase             r_ph;
    t_sin_data          n_q;
    t_sin_data          r_q;
    t_sin_data          n_x;
    t_sin_data          r_x;
    t_sin_data          n_x2;
    t_sin_data          r_x2;
    t_sin_data          w_chain [0:TAYLOR_STEPS];
    logic [61:0]        w_px;
    logic [61:0]        w_pxx;
    logic [61:0]        w_pxt;
    logic [30:0]        n_s;
    logic [30:0]        r_s;
    t_sin_data          r_sd;
    logic [31:0]        w_rs;
    t_sin_res           n_res;
    t_sin_res           r_res;

    assign w_pm = 48'(i_req.angle) * INV_TWO_PI_Q32;
    assign w_pr = w_pm + 48'sd4096;

    always_comb begin
        n_ph.valid = i_req.valid;
        n_ph.tag   = i_req.tag;
        n_ph.phase = w_pr[44:13] + (i_req.is_cos ? 32'h4000_0000 : 32'd0);
    end

    always_comb begin
        n_q       = '0;
        n_q.valid = r_ph.valid;
        n_q.tag   = r_ph.tag;
        n_q.neg   = r_ph.phase[31];
        n_q.x     = r_ph.phase[30] ? (ONE_Q30 - {1'b0, r_ph.phase[29:0]})
                                   : {1'b0, r_ph.phase[29:0]};
    end

    assign w_px = 62'(r_q.x) * 62'(HALF_PI_Q30);
    always_comb begin
        n_x   = r_q;
        n_x.x = w_px[60:30];
    end

    assign w_pxx = 62'(r_x.x) * 62'(r_x.x);
    always_comb begin
        n_x2    = r_x;
        n_x2.x2 = w_pxx[61:30];
        n_x2.t  = ONE_Q30;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph.valid  <= 1'b0;
            r_q.valid   <= 1'b0;
            r_x.valid   <= 1'b0;
            r_x2.valid  <= 1'b0;
            r_sd.valid  <= 1'b0;
            r_res.valid <= 1'b0;
        end else if (i_en) begin
            r_ph  <= n_ph;
            r_q   <= n_q;
            r_x   <= n_x;
            r_x2  <= n_x2;
            r_sd  <= w_chain[TAYLOR_STEPS];
            r_res <= n_res;
        end
    end

    assign w_chain[0] = r_x2;

    for (genvar k = 0; k < TAYLOR_STEPS; k++) begin : g_cell
        ltcr_taylor_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_step  (3'(k)),
            .i_d     (w_chain[k]),
            .o_d     (w_chain[k+1])
        );
    end

    assign w_pxt = 62'(w_chain[TAYLOR_STEPS].x) * 62'(w_chain[TAYLOR_STEPS].t);
    assign n_s   = w_pxt[60:30];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= n_s;
        end
    end

    assign w_rs = 32'(r_s) + 32'd8192;

    always_comb begin
        n_res.valid = r_sd.valid;
        n_res.tag   = r_sd.tag;
        n_res.value = r_sd.neg ? -$signed({1'b0, w_rs[30:14]})
                               : $signed({1'b0, w_rs[30:14]});
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

[sv/ltcr_row_unit.sv]
// Row builder: Jacobian products, gravity torque, bounds and output register.
// Depends on ltcr_pkg.
`default_nettype none

module ltcr_row_unit (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire                  i_start,
    input  ltcr_pkg::t_trig      i_trig,
    input  ltcr_pkg::t_limits    i_lim,
    output logic                 o_valid,
    output ltcr_pkg::t_out_item  o_item
);
    import ltcr_pkg::*;

    t_trig              r_t;
    logic signed [18:0] r_h;
    logic signed [18:0] r_g;
    logic               r_active;
    logic [2:0]         r_row;

    t_col               w_col;
    logic               w_neg;
    logic signed [18:0] w_a1;
    logic signed [18:0] w_b1;
    logic signed [18:0] w_a2;
    logic signed [18:0] w_b2;
    logic signed [18:0] w_j2;

    logic               r1_valid;
    logic [2:0]         r1_row;
    t_col               r1_col;
    logic               r1_neg;
    logic [2:0]         r1_leg;
    logic               r1_final;
    logic signed [37:0] r1_m1;
    logic signed [37:0] r1_m2;
    logic signed [18:0] r1_j2;
    logic signed [40:0] r1_g1;
    logic signed [40:0] r1_g2;
    logic signed [40:0] r1_g3;

    logic signed [37:0] w_m1r;
    logic signed [37:0] w_m2r;
    logic signed [18:0] w_j2r;
    logic signed [42:0] w_gs;
    logic [30:0]        w_lim;

    logic               r2_valid;
    logic [2:0]         r2_row;
    logic               r2_neg;
    logic [2:0]         r2_leg;
    logic               r2_final;
    logic signed [20:0] r2_j0;
    logic signed [20:0] r2_j1;
    logic signed [17:0] r2_j2;
    logic signed [26:0] r2_grav;
    logic [30:0]        r2_lim;

    logic signed [33:0] w_b;
    logic signed [31:0] w_bs;
    t_out_item          n_item;
    logic               r_out_valid;
    t_out_item          r_item;

    always_ff @(posedge i_clk) begin
        if (i_en && i_start) begin
            r_t <= i_trig;
            r_h <= 19'(i_trig.s23) + 19'(i_trig.c2) + OFFSET_Q17;
            r_g <= 19'(i_trig.c23) - 19'(i_trig.s2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_row    <= 3'd0;
        end else if (i_en) begin
            if (i_start) begin
                r_active <= 1'b1;
                r_row    <= 3'd0;
            end else if (r_active) begin
                if (r_row == ROW_LAST) begin
                    r_active <= 1'b0;
                    r_row    <= 3'd0;
                end else begin
                    r_row <= r_row + 3'd1;
                end
            end
        end
    end

    always_comb begin
        w_neg = (r_row >= ROW_NEG_FIRST);
        case (r_row)
            3'd0, 3'd3: w_col = COL_HIP;
            3'd1, 3'd4: w_col = COL_UPPER;
            default:    w_col = COL_LOWER;
        endcase
        case (w_col)
            COL_HIP: begin
                w_a1 = -19'(r_t.s1);
                w_b1 = r_h;
                w_a2 = 19'(r_t.c1);
                w_b2 = r_h;
                w_j2 = '0;
            end
            COL_UPPER: begin
                w_a1 = 19'(r_t.c1);
                w_b1 = r_g;
                w_a2 = 19'(r_t.s1);
                w_b2 = r_g;
                w_j2 = 19'(r_t.s23) + 19'(r_t.c2);
            end
            default: begin
                w_a1 = 19'(r_t.c23);
                w_b1 = 19'(r_t.c1);
                w_a2 = 19'(r_t.c23);
                w_b2 = 19'(r_t.s1);
                w_j2 = 19'(r_t.s23);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_row   <= r_row;
            r1_col   <= w_col;
            r1_neg   <= w_neg;
            r1_leg   <= r_t.leg;
            r1_final <= r_t.final_leg;
            r1_m1    <= 38'(w_a1) * 38'(w_b1);
            r1_m2    <= 38'(w_a2) * 38'(w_b2);
            r1_j2    <= w_j2;
            r1_g1    <= 41'(r_t.c23) * GRAV_K1;
            r1_g2    <= 41'(r_t.s23) * GRAV_K2;
            r1_g3    <= 41'(r_t.c2) * GRAV_K3;
        end
    end

    assign w_m1r = r1_m1 + 38'sd65536;
    assign w_m2r = r1_m2 + 38'sd65536;
    assign w_j2r = r1_j2 + 19'sd1;

    always_comb begin
        case (r1_col)
            COL_HIP: begin
                w_gs  = '0;
                w_lim = i_lim.hip;
            end
            COL_UPPER: begin
                w_gs  = 43'(r1_g1) + 43'(r1_g2) - 43'(r1_g3) + 43'sd32768;
                w_lim = i_lim.upper;
            end
            default: begin
                w_gs  = 43'(r1_g2) + 43'sd32768;
                w_lim = i_lim.lower;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_row   <= r1_row;
            r2_neg   <= r1_neg;
            r2_leg   <= r1_leg;
            r2_final <= r1_final;
            r2_j0    <= w_m1r[37:17];
            r2_j1    <= w_m2r[37:17];
            r2_j2    <= w_j2r[18:1];
            r2_grav  <= (r1_col == COL_HIP) ? 27'sd0 : w_gs[42:16];
            r2_lim   <= w_lim;
        end
    end

    assign w_b = r2_neg ? ($signed({3'b000, r2_lim}) + 34'(r2_grav))
                        : ($signed({3'b000, r2_lim}) - 34'(r2_grav));

    always_comb begin
        if (w_b > 34'sd2147483647) begin
            w_bs = 32'sh7fff_ffff;
        end else if (w_b < -34'sd2147483648) begin
            w_bs = 32'sh8000_0000;
        end else begin
            w_bs = w_b[31:0];
        end
        n_item.leg_number  = r2_leg;
        n_item.row_in_leg  = r2_row;
        n_item.coef_first  = r2_neg ? -32'(r2_j0) : 32'(r2_j0);
        n_item.coef_second = r2_neg ? -32'(r2_j1) : 32'(r2_j1);
        n_item.coef_third  = r2_neg ? -32'(r2_j2) : 32'(r2_j2);
        n_item.row_bound   = w_bs;
        n_item.last_row    = (r2_row == ROW_LAST);
        n_item.last_of_set = (r2_row == ROW_LAST) && r2_final;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid    <= r_active;
            r2_valid    <= r1_valid;
            r_out_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

[sv/leg_torque_constraint_rows_core.sv]
// Leg torque constraint rows: top level with input slot feeder, gather and APB registers.
// Depends on ltcr_pkg, ltcr_sine_pipe and ltcr_row_unit.
//
// Usage:
//   Input channel (i_in_valid/o_in_ready, i_in_item) takes one leg: index, three
//   joint angles, final flag. Output channel (o_out_valid/i_out_ready, o_out_item)
//   gives six rows per leg, row_in_leg 0..5 in order, last_row on row 5.
//   The six sines and cosines of a leg pass one per cycle, while the output is not
//   stalled, through a chain of Taylor cells; a new item can be accepted while the
//   slot feeder issues the last request of the item before.
//   Each leg passes the input register, sine pipeline, gather registers and row unit in order.
//   Torque limits are written over the APB port (0x0 hip, 0x4 upper, 0x8 lower); the user
//   must write them only while the block is idle, which the block does not enforce; reads return the stored value.
//   Reset empties every stage and loads the default limits.
//   A stalled output freezes the whole pipeline; one input item can still be
//   taken into the input register while the output waits.
`default_nettype none

module leg_torque_constraint_rows_core (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  ltcr_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output ltcr_pkg::t_out_item                 o_out_item,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [ltcr_pkg::ADDR_W-1:0]         paddr,
    input  wire  [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import ltcr_pkg::*;

    logic               w_en;
    logic               w_accept;
    logic               r_in_full;
    logic [2:0]         r_slot;
    t_in_item           r_in;
    t_sin_req           w_req;
    t_sin_res           w_res;
    logic signed [17:0] r_gs1;
    logic signed [17:0] r_gc1;
    logic signed [17:0] r_gs2;
    logic signed [17:0] r_gc2;
    logic signed [17:0] r_gs23;
    logic               w_start;
    t_trig              w_trig;
    t_limits            r_lim;
    logic               w_row_valid;
    t_out_item          w_row_item;
    t_reg_idx           w_idx;

    assign w_en       = !w_row_valid || i_out_ready;
    assign o_in_ready = !r_in_full || (w_en && (r_slot == SLOT_LAST));
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_full <= 1'b0;
            r_slot    <= 3'd0;
        end else if (w_accept) begin
            r_in_full <= 1'b1;
            r_slot    <= 3'd0;
        end else if (w_en && r_in_full) begin
            if (r_slot == SLOT_LAST) begin
                r_in_full <= 1'b0;
                r_slot    <= 3'd0;
            end else begin
                r_slot <= r_slot + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_item;
        end
    end

    always_comb begin
        w_req.valid         = r_in_full;
        w_req.tag.leg       = r_in.leg_index;
        w_req.tag.final_leg = r_in.final_leg;
        w_req.tag.slot      = r_slot;
        w_req.is_cos        = r_slot[0];
        case (r_slot[2:1])
            2'd0:    w_req.angle = 17'(r_in.angle_hip);
            2'd1:    w_req.angle = 17'(r_in.angle_upper);
            default: w_req.angle = 17'(r_in.angle_upper) + 17'(r_in.angle_lower);
        endcase
    end

    ltcr_sine_pipe u_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_req   (w_req),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (w_en && w_res.valid) begin
            case (w_res.tag.slot)
                SLOT_SIN_HIP:   r_gs1  <= w_res.value;
                SLOT_COS_HIP:   r_gc1  <= w_res.value;
                SLOT_SIN_UPPER: r_gs2  <= w_res.value;
                SLOT_COS_UPPER: r_gc2  <= w_res.value;
                SLOT_SIN_SUM:   r_gs23 <= w_res.value;
                default: ;
            endcase
        end
    end

    assign w_start = w_res.valid && (w_res.tag.slot == SLOT_LAST);

    always_comb begin
        w_trig.leg       = w_res.tag.leg;
        w_trig.final_leg = w_res.tag.final_leg;
        w_trig.s1        = r_gs1;
        w_trig.c1        = r_gc1;
        w_trig.s2        = r_gs2;
        w_trig.c2        = r_gc2;
        w_trig.s23       = r_gs23;
        w_trig.c23       = w_res.value;
    end

    ltcr_row_unit u_rows (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_start (w_start),
        .i_trig  (w_trig),
        .i_lim   (r_lim),
        .o_valid (w_row_valid),
        .o_item  (w_row_item)
    );

    assign o_out_valid = w_row_valid;
    assign o_out_item  = w_row_item;

    assign w_idx  = paddr[ADDR_W-1:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim.hip   <= RESET_LIMIT_HIP;
            r_lim.upper <= RESET_LIMIT_UPPER;
            r_lim.lower <= RESET_LIMIT_LOWER;
        end else if (psel && penable && pwrite && pready) begin
            case (w_idx)
                REG_LIMIT_HIP:   r_lim.hip   <= pwdata[30:0];
                REG_LIMIT_UPPER: r_lim.upper <= pwdata[30:0];
                REG_LIMIT_LOWER: r_lim.lower <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_LIMIT_HIP:   prdata = {1'b0, r_lim.hip};
            REG_LIMIT_UPPER: prdata = {1'b0, r_lim.upper};
            REG_LIMIT_LOWER: prdata = {1'b0, r_lim.lower};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

[sv/ltcr_checker.sv]
// Port checker for the leg torque constraint rows block, bound to the top level.
// Depends on ltcr_pkg and leg_torque_constraint_rows_core_defines.svh.
`default_nettype none
`include "leg_torque_constraint_rows_core_defines.svh"

module ltcr_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_out_valid,
    input wire                 i_out_ready,
    input ltcr_pkg::t_out_item i_out_item
);
    import ltcr_pkg::*;

    `LTCR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_item))
    `LTCR_ASSERT_NEXT(a_row_step, i_clk, i_rst_n, i_out_valid && i_out_ready && (i_out_item.row_in_leg != ROW_LAST), i_out_valid && (i_out_item.row_in_leg == 3'($past(i_out_item.row_in_leg) + 3'd1)) && (i_out_item.leg_number == $past(i_out_item.leg_number)))
    `LTCR_ASSERT_IMPL(a_last_row, i_clk, i_rst_n, i_out_valid, (i_out_item.row_in_leg <= ROW_LAST) && (i_out_item.last_row == (i_out_item.row_in_leg == ROW_LAST)))
    `LTCR_ASSERT_IMPL(a_last_set, i_clk, i_rst_n, i_out_valid && i_out_item.last_of_set, i_out_item.last_row)

endmodule

bind leg_torque_constraint_rows_core ltcr_checker u_ltcr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_item  (o_out_item)
);

`default_nettype wire

[test/tb_leg_torque_constraint_rows_core.sv]
// Testbench for leg_torque_constraint_rows_core: drives leg items and APB limit writes,
// predicts the six constraint rows per leg and checks every output row in order.
// Depends on ltcr_pkg and the leg_torque_constraint_rows_core RTL.
`default_nettype none

module tb_leg_torque_constraint_rows_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ltcr_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 4000;
    localparam int N_REGS       = 3;
    localparam logic [ADDR_W-1:0] ADDR_BEYOND = 4'd12;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                o_in_ready;
    t_in_item            in_item = '0;
    logic                o_out_valid;
    logic                out_ready = 1'b0;
    t_out_item           o_out_item;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    logic [30:0] limits [N_REGS];
    t_out_item   rows_due[$];
    int          errors = 0;
    bit          in_hs = 1'b0;
    bit          out_hs = 1'b0;
    bit          no_idle = 1'b0;
    int          ready_wait = 0;
    int          quiet_cycles = 0;

    leg_torque_constraint_rows_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [31:0] angle_phase(input logic signed [63:0] a);
        logic signed [63:0] p;
        logic [63:0] u;
        p = a * 64'sd683565276;
        u = p + 64'd4096;
        return u[44:13];
    endfunction

    function automatic logic signed [63:0] sine_q16(input logic [31:0] ph);
        logic [63:0] u, x, x2, t, s;
        logic [63:0] divs [5];
        divs = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
        u = ph[30] ? (64'h4000_0000 - {34'd0, ph[29:0]}) : {34'd0, ph[29:0]};
        x = (u * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        t = 64'h4000_0000;
        for (int k = 0; k < 5; k++)
            t = 64'h4000_0000 - ((x2 * t) >> 30) / divs[k];
        s = (((x * t) >> 30) + 64'd8192) >> 14;
        return ph[31] ? -$signed(s) : $signed(s);
    endfunction

    function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic void predict_rows(input t_in_item it);
        logic signed [63:0] s1, c1, s2, c2, s23, c23, h, g, bnd;
        logic signed [63:0] a1, a2, a23;
        logic signed [63:0] jac [3][3];
        logic signed [63:0] grav [3];
        logic [31:0] ph;
        t_out_item row;
        a1 = it.angle_hip;
        a2 = it.angle_upper;
        a23 = a2 + 64'(it.angle_lower);
        ph = angle_phase(a1);
        s1 = sine_q16(ph);
        c1 = sine_q16(ph + 32'h4000_0000);
        ph = angle_phase(a2);
        s2 = sine_q16(ph);
        c2 = sine_q16(ph + 32'h4000_0000);
        ph = angle_phase(a23);
        s23 = sine_q16(ph);
        c23 = sine_q16(ph + 32'h4000_0000);
        h = s23 + c2 + 64'sd23593;
        g = c23 - s2;
        jac[0][0] = rnd(-s1 * h, 17);
        jac[0][1] = rnd(c1 * g, 17);
        jac[0][2] = rnd(c23 * c1, 17);
        jac[1][0] = rnd(c1 * h, 17);
        jac[1][1] = rnd(s1 * g, 17);
        jac[1][2] = rnd(c23 * s1, 17);
        jac[2][0] = 0;
        jac[2][1] = rnd(s23 + c2, 1);
        jac[2][2] = rnd(s23, 1);
        grav[0] = 0;
        grav[1] = rnd(64'sd6471802 * c23 + 64'sd1189669 * s23 - 64'sd558798 * c2, 16);
        grav[2] = rnd(64'sd1189669 * s23, 16);
        for (int r = 0; r < 6; r++) begin
            int col;
            bit neg;
            col = r % 3;
            neg = (r >= 3);
            bnd = neg ? 64'(limits[col]) + grav[col] : 64'(limits[col]) - grav[col];
            row.leg_number  = it.leg_index;
            row.row_in_leg  = 3'(r);
            row.coef_first  = sat32(neg ? -jac[0][col] : jac[0][col]);
            row.coef_second = sat32(neg ? -jac[1][col] : jac[1][col]);
            row.coef_third  = sat32(neg ? -jac[2][col] : jac[2][col]);
            row.row_bound   = sat32(bnd);
            row.last_row    = (r == 5);
            row.last_of_set = (r == 5) && it.final_leg;
            rows_due.push_back(row);
        end
    endfunction

    // handshakes are decided at the falling edge, where all signals are settled
    always @(negedge i_clk) begin
        in_hs = i_rst_n && in_valid && o_in_ready;
        out_hs = i_rst_n && o_out_valid && out_ready;
        if (out_hs) begin
            if (rows_due.size() == 0) begin
                $display("%0t: unexpected row, actual %p", $time, o_out_item);
                errors++;
            end else begin
                t_out_item exp_row;
                exp_row = rows_due.pop_front();
                if (o_out_item.leg_number !== exp_row.leg_number)
                    $display("%0t: leg_number expected %0d actual %0d", $time,
                             exp_row.leg_number, o_out_item.leg_number);
                if (o_out_item.row_in_leg !== exp_row.row_in_leg)
                    $display("%0t: row_in_leg expected %0d actual %0d", $time,
                             exp_row.row_in_leg, o_out_item.row_in_leg);
                if (o_out_item.coef_first !== exp_row.coef_first)
                    $display("%0t: coef_first expected %0d actual %0d", $time,
                             exp_row.coef_first, o_out_item.coef_first);
                if (o_out_item.coef_second !== exp_row.coef_second)
                    $display("%0t: coef_second expected %0d actual %0d", $time,
                             exp_row.coef_second, o_out_item.coef_second);
                if (o_out_item.coef_third !== exp_row.coef_third)
                    $display("%0t: coef_third expected %0d actual %0d", $time,
                             exp_row.coef_third, o_out_item.coef_third);
                if (o_out_item.row_bound !== exp_row.row_bound)
                    $display("%0t: row_bound expected %0d actual %0d", $time,
                             exp_row.row_bound, o_out_item.row_bound);
                if (o_out_item.last_row !== exp_row.last_row)
                    $display("%0t: last_row expected %0b actual %0b", $time,
                             exp_row.last_row, o_out_item.last_row);
                if (o_out_item.last_of_set !== exp_row.last_of_set)
                    $display("%0t: last_of_set expected %0b actual %0b", $time,
                             exp_row.last_of_set, o_out_item.last_of_set);
                if (o_out_item !== exp_row)
                    errors++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (ready_wait > 0) begin
            out_ready <= 1'b0;
            ready_wait <= ready_wait - 1;
        end else begin
            out_ready <= 1'b1;
            if (out_hs && !no_idle)
                ready_wait <= $urandom_range(0, 6);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || in_hs || out_hs)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("leg_torque_constraint_rows_core verification failed");
            $finish;
        end
    end

    task automatic send_leg(input t_in_item it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge i_clk); while (!in_hs);
        predict_rows(it);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (rows_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr < ADDR_W'(4 * N_REGS))
            limits[addr >> 2] = data[30:0];
    endtask

    task automatic apb_check(input logic [ADDR_W-1:0] addr);
        psel <= 1'b1;
        pwrite <= 1'b0;
        penable <= 1'b0;
        paddr <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata !== {1'b0, limits[addr >> 2]}) begin
            $display("%0t: register 0x%0h expected %0h actual %0h", $time, addr,
                     {1'b0, limits[addr >> 2]}, prdata);
            errors++;
        end
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_limits(input logic [31:0] hip, upper, lower);
        apb_write({REG_LIMIT_HIP, 2'b00}, hip);
        apb_write({REG_LIMIT_UPPER, 2'b00}, upper);
        apb_write({REG_LIMIT_LOWER, 2'b00}, lower);
        apb_check({REG_LIMIT_HIP, 2'b00});
        apb_check({REG_LIMIT_UPPER, 2'b00});
        apb_check({REG_LIMIT_LOWER, 2'b00});
    endtask

    function automatic t_in_item rand_leg(input bit near_zero);
        t_in_item it;
        it.leg_index = 3'($urandom_range(0, 7));
        it.final_leg = 1'($urandom_range(0, 1));
        if (near_zero) begin
            it.angle_hip   = 16'($signed($urandom_range(0, 25736)) - 12868);
            it.angle_upper = 16'($signed($urandom_range(0, 25736)) - 12868);
            it.angle_lower = 16'($signed($urandom_range(0, 25736)) - 12868);
        end else begin
            it.angle_hip   = 16'($urandom);
            it.angle_upper = 16'($urandom);
            it.angle_lower = 16'($urandom);
        end
        return it;
    endfunction

    task automatic test_directed_angles;
        logic signed [15:0] pts [8];
        pts = '{16'sd0, 16'sd12868, -16'sd12868, 16'sd25736, 16'sd32767,
                -16'sd32768, 16'sd1, -16'sd1};
        for (int k = 0; k < 8; k++)
            send_leg('{leg_index: 3'(k), angle_hip: pts[k], angle_upper: pts[(k + 3) % 8],
                       angle_lower: pts[(k + 5) % 8], final_leg: k[0]});
        send_leg('{leg_index: 3'd7, angle_hip: 16'sh7FFF, angle_upper: 16'sh7FFF,
                   angle_lower: 16'sh7FFF, final_leg: 1'b1});
        send_leg('{leg_index: 3'd0, angle_hip: -16'sd32768, angle_upper: -16'sd32768,
                   angle_lower: -16'sd32768, final_leg: 1'b0});
        drain();
    endtask

    task automatic test_limit_extremes;
        // top limits push the positive-gravity bounds into saturation
        set_limits(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        apb_write(ADDR_BEYOND, 32'h1234_5678);
        set_limits(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        for (int k = 0; k < 6; k++)
            send_leg(rand_leg(k[0]));
        drain();
        set_limits(32'd0, 32'd0, 32'd0);
        for (int k = 0; k < 6; k++)
            send_leg(rand_leg(k[0]));
        drain();
    endtask

    task automatic test_random_legs;
        for (int phase = 0; phase < 4; phase++) begin
            set_limits($urandom, $urandom, $urandom);
            no_idle = (phase == 2);
            for (int k = 0; k < 28; k++)
                send_leg(rand_leg($urandom_range(0, 3) == 0));
            drain();
            no_idle = 1'b0;
        end
    endtask

    initial begin
        limits[0] = RESET_LIMIT_HIP;
        limits[1] = RESET_LIMIT_UPPER;
        limits[2] = RESET_LIMIT_LOWER;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_angles();
        test_limit_extremes();
        test_random_legs();
        if (errors == 0)
            $display("leg_torque_constraint_rows_core verification clean");
        else
            $display("leg_torque_constraint_rows_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire
